// File: rtl/lbcd_pkg.sv
`timescale 1ns / 1ps

package lbcd_pkg;

    localparam logic [3:0] OP_LOOKUP      = 4'd0;
    localparam logic [3:0] OP_FILL        = 4'd1;
    localparam logic [3:0] OP_PROBE       = 4'd2;
    localparam logic [3:0] OP_MARK_DIRTY  = 4'd3;
    localparam logic [3:0] OP_CLEAR_DIRTY = 4'd4;
    localparam logic [3:0] OP_INVALIDATE  = 4'd5;
    localparam logic [3:0] OP_FLUSH       = 4'd6;
    localparam logic [3:0] OP_CLEAR_ALL   = 4'd7;
    localparam logic [3:0] OP_CLEAN_ALL   = 4'd8;
    localparam logic [3:0] OP_RESET_STATS = 4'd9;

    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_EVICT  = 2'd1;
    localparam logic [1:0] KIND_FLUSH  = 2'd2;

    localparam logic CFG_CAPACITY      = 1'b0;
    localparam logic CFG_WRITE_THROUGH = 1'b1;

    localparam logic [4:0] CAPACITY_RESET = 5'd16;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MATCH,
        S_EVICT,
        S_FLUSH,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic match;
        logic evict;
        logic flush_step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic req_valid;
        logic out_free;
        logic is_fill;
        logic is_flush;
        logic need_evict;
        logic flush_done;
        logic flush_emit;
    } t_status;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

endpackage

// File: rtl/lbcd_if.sv
`timescale 1ns / 1ps

interface lbcd_req_if;
    logic        valid;
    logic        ready;
    logic [3:0]  op;
    logic [31:0] block;
    logic        dirty_in;

    modport source (output valid, output op, output block, output dirty_in, input ready);
    modport sink (input valid, input op, input block, input dirty_in, output ready);
endinterface

interface lbcd_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] report_block;
    logic        found;
    logic        dirty_out;
    logic [3:0]  slot;
    logic        last;
    logic [4:0]  occupancy;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
    logic [31:0] evict_total;

    modport source (output valid, output kind, output report_block, output found,
                    output dirty_out, output slot, output last, output occupancy,
                    output hit_total, output miss_total, output evict_total,
                    input ready);
    modport sink (input valid, input kind, input report_block, input found,
                  input dirty_out, input slot, input last, input occupancy,
                  input hit_total, input miss_total, input evict_total,
                  output ready);
endinterface

// File: rtl/lbcd_ctrl.sv
`timescale 1ns / 1ps

module lbcd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  lbcd_pkg::t_status i_status,
    output lbcd_pkg::t_cmd   o_cmd
);

    lbcd_pkg::t_state r_state;
    lbcd_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lbcd_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            lbcd_pkg::S_IDLE: begin
                if (i_status.req_valid) begin
                    n_state = lbcd_pkg::S_MATCH;
                end
            end
            lbcd_pkg::S_MATCH: begin
                if (i_status.is_flush) begin
                    n_state = lbcd_pkg::S_FLUSH;
                end else if (i_status.is_fill) begin
                    n_state = lbcd_pkg::S_EVICT;
                end else begin
                    n_state = lbcd_pkg::S_FINISH;
                end
            end
            lbcd_pkg::S_EVICT: begin
                if (!i_status.need_evict) begin
                    n_state = lbcd_pkg::S_FINISH;
                end
            end
            lbcd_pkg::S_FLUSH: begin
                if (i_status.flush_done) begin
                    n_state = lbcd_pkg::S_FINISH;
                end
            end
            lbcd_pkg::S_FINISH: begin
                if (i_status.out_free) begin
                    n_state = lbcd_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = lbcd_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            lbcd_pkg::S_IDLE: begin
                o_cmd.in_ready = 1'b1;
            end
            lbcd_pkg::S_MATCH: begin
                o_cmd.match = 1'b1;
            end
            lbcd_pkg::S_EVICT: begin
                o_cmd.evict = i_status.need_evict & i_status.out_free;
            end
            lbcd_pkg::S_FLUSH: begin
                o_cmd.flush_step = ~i_status.flush_done
                                 & (~i_status.flush_emit | i_status.out_free);
            end
            lbcd_pkg::S_FINISH: begin
                o_cmd.finish = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// File: rtl/lbcd_datapath.sv
`timescale 1ns / 1ps

module lbcd_datapath #(
    parameter int ENTRIES        = 16,
    parameter int BLOCK_NUM_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lbcd_pkg::t_cmd    i_cmd,
    output lbcd_pkg::t_status o_status,
    output logic              o_load,
    input  logic              i_cfg_wr_en,
    input  logic              i_cfg_index,
    input  logic [4:0]        i_cfg_data,
    lbcd_req_if.sink          i_req,
    lbcd_rsp_if.source        o_rsp
);

    localparam int RW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int KB = (BLOCK_NUM_BITS < 32) ? BLOCK_NUM_BITS : 32;
    localparam logic [8:0] ENT9 = 9'(ENTRIES);

    logic [KB-1:0] r_block [ENTRIES];
    logic [RW-1:0] r_rank  [ENTRIES];
    logic [ENTRIES-1:0] r_valid, n_valid;
    logic [ENTRIES-1:0] r_dirty, n_dirty;
    logic [RW-1:0] n_rank [ENTRIES];
    logic [CW-1:0] r_vc, n_vc;
    logic [31:0] r_hits, n_hits, r_miss, n_miss, r_evs, n_evs;
    logic [4:0]  r_cap;
    logic        r_wt;
    logic [3:0]  r_op;
    logic [KB-1:0] r_blk;
    logic        r_din;
    logic        r_hit;
    logic [RW-1:0] r_hslot;
    logic        r_hdirty;
    logic [CW-1:0] r_frank;
    logic        r_ov;
    logic [1:0]  r_kind, n_kind;
    logic [31:0] r_rblk, n_rblk;
    logic        r_found, n_found, r_dout, n_dout, r_last;
    logic [3:0]  r_slot, n_slot;

    logic          m_hit, ev_found, fl_found, fr_found, out_free, has_blk, emit;
    logic [RW-1:0] m_slot, ev_slot, fl_slot, fr_slot, vc_m1, rr;
    logic [8:0]    cap_eff, vc9;

    assign has_blk  = (r_op <= lbcd_pkg::OP_INVALIDATE);
    assign out_free = ~r_ov | o_rsp.ready;
    assign o_load   = i_cmd.in_ready & i_req.valid;
    assign vc_m1    = RW'(r_vc - CW'(1));
    assign vc9      = 9'(r_vc);

    always_comb begin
        m_hit = 1'b0; m_slot = '0;
        ev_found = 1'b0; ev_slot = '0;
        fl_found = 1'b0; fl_slot = '0;
        fr_found = 1'b0; fr_slot = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (r_valid[i] && r_block[i] == r_blk) begin
                m_hit = 1'b1; m_slot = RW'(i);
            end
            if (r_valid[i] && r_rank[i] == vc_m1) begin
                ev_found = 1'b1; ev_slot = RW'(i);
            end
            if (r_valid[i] && r_rank[i] == RW'(r_frank)) begin
                fl_found = 1'b1; fl_slot = RW'(i);
            end
            if (!r_valid[i]) begin
                fr_found = 1'b1; fr_slot = RW'(i);
            end
        end
        if (r_cap == 5'd0) begin
            cap_eff = 9'd1;
        end else if (9'(r_cap) > ENT9) begin
            cap_eff = ENT9;
        end else begin
            cap_eff = 9'(r_cap);
        end
    end

    assign o_status.req_valid  = i_req.valid;
    assign o_status.out_free   = out_free;
    assign o_status.is_fill    = (r_op == lbcd_pkg::OP_FILL);
    assign o_status.is_flush   = (r_op == lbcd_pkg::OP_FLUSH);
    assign o_status.need_evict = (r_op == lbcd_pkg::OP_FILL) & ~r_hit & (vc9 >= cap_eff)
                               & (r_vc != '0) & ev_found;
    assign o_status.flush_done = (r_frank >= r_vc);
    assign o_status.flush_emit = fl_found & r_dirty[fl_slot];

    always_comb begin
        n_valid = r_valid; n_dirty = r_dirty; n_rank = r_rank; n_vc = r_vc;
        n_hits = r_hits; n_miss = r_miss; n_evs = r_evs;
        n_kind = lbcd_pkg::KIND_STATUS;
        n_rblk = has_blk ? 32'(r_blk) : 32'd0;
        n_found = r_hit;
        n_dout = r_hit & r_hdirty;
        n_slot = r_hit ? 4'(r_hslot) : 4'd0;
        emit = 1'b0;
        rr = r_rank[r_hslot];
        if (i_cmd.evict) begin
            emit = 1'b1;
            n_kind = lbcd_pkg::KIND_EVICT;
            n_rblk = 32'(r_block[ev_slot]);
            n_found = 1'b0;
            n_dout = r_dirty[ev_slot];
            n_slot = 4'(ev_slot);
            n_valid[ev_slot] = 1'b0;
            n_dirty[ev_slot] = 1'b0;
            n_vc = r_vc - CW'(1);
            n_evs = lbcd_pkg::sat_inc(r_evs);
        end
        if (i_cmd.flush_step && o_status.flush_emit) begin
            emit = 1'b1;
            n_kind = lbcd_pkg::KIND_FLUSH;
            n_rblk = 32'(r_block[fl_slot]);
            n_found = 1'b0;
            n_dout = 1'b1;
            n_slot = 4'(fl_slot);
            n_dirty[fl_slot] = 1'b0;
        end
        if (i_cmd.finish) begin
            emit = 1'b1;
            case (r_op)
                lbcd_pkg::OP_LOOKUP: begin
                    if (r_hit) begin
                        for (int j = 0; j < ENTRIES; j++) begin
                            if (r_valid[j] && r_rank[j] < rr) n_rank[j] = r_rank[j] + RW'(1);
                        end
                        n_rank[r_hslot] = '0;
                        n_hits = lbcd_pkg::sat_inc(r_hits);
                    end else begin
                        n_miss = lbcd_pkg::sat_inc(r_miss);
                    end
                end
                lbcd_pkg::OP_FILL: begin
                    if (r_hit) begin
                        n_dirty[r_hslot] = ~r_wt & (r_hdirty | r_din);
                        n_dout = ~r_wt & (r_hdirty | r_din);
                        for (int j = 0; j < ENTRIES; j++) begin
                            if (r_valid[j] && r_rank[j] < rr) n_rank[j] = r_rank[j] + RW'(1);
                        end
                        n_rank[r_hslot] = '0;
                    end else if (fr_found) begin
                        for (int j = 0; j < ENTRIES; j++) begin
                            if (r_valid[j]) n_rank[j] = r_rank[j] + RW'(1);
                        end
                        n_valid[fr_slot] = 1'b1;
                        n_dirty[fr_slot] = ~r_wt & r_din;
                        n_rank[fr_slot] = '0;
                        n_vc = r_vc + CW'(1);
                        n_slot = 4'(fr_slot);
                        n_dout = ~r_wt & r_din;
                    end
                end
                lbcd_pkg::OP_MARK_DIRTY: begin
                    if (r_hit) begin
                        n_dirty[r_hslot] = 1'b1;
                        n_dout = 1'b1;
                    end
                end
                lbcd_pkg::OP_CLEAR_DIRTY: begin
                    if (r_hit) begin
                        n_dirty[r_hslot] = 1'b0;
                        n_dout = 1'b0;
                    end
                end
                lbcd_pkg::OP_INVALIDATE: begin
                    if (r_hit) begin
                        n_valid[r_hslot] = 1'b0;
                        n_dirty[r_hslot] = 1'b0;
                        for (int j = 0; j < ENTRIES; j++) begin
                            if (r_valid[j] && r_rank[j] > rr) n_rank[j] = r_rank[j] - RW'(1);
                        end
                        if (r_vc != '0) n_vc = r_vc - CW'(1);
                    end
                end
                lbcd_pkg::OP_CLEAR_ALL: begin
                    n_valid = '0;
                    n_dirty = '0;
                    n_vc = '0;
                end
                lbcd_pkg::OP_CLEAN_ALL: begin
                    n_dirty = '0;
                end
                lbcd_pkg::OP_RESET_STATS: begin
                    n_hits = '0;
                    n_miss = '0;
                    n_evs = '0;
                end
                default: begin
                    n_kind = lbcd_pkg::KIND_STATUS;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_dirty <= '0;
            r_vc    <= '0;
            r_hits  <= '0;
            r_miss  <= '0;
            r_evs   <= '0;
            r_cap   <= lbcd_pkg::CAPACITY_RESET;
            r_wt    <= 1'b0;
            r_ov    <= 1'b0;
            r_frank <= '0;
        end else begin
            r_valid <= n_valid;
            r_dirty <= n_dirty;
            r_vc    <= n_vc;
            r_hits  <= n_hits;
            r_miss  <= n_miss;
            r_evs   <= n_evs;
            if (i_cfg_wr_en && i_cfg_index == lbcd_pkg::CFG_CAPACITY) r_cap <= i_cfg_data;
            if (i_cfg_wr_en && i_cfg_index == lbcd_pkg::CFG_WRITE_THROUGH) r_wt <= i_cfg_data[0];
            if (emit) begin
                r_ov <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ov <= 1'b0;
            end
            if (o_load) begin
                r_frank <= '0;
            end else if (i_cmd.flush_step) begin
                r_frank <= r_frank + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rank <= n_rank;
        if (i_cmd.finish && r_op == lbcd_pkg::OP_FILL && !r_hit && fr_found) begin
            r_block[fr_slot] <= r_blk;
        end
        if (o_load) begin
            r_op  <= i_req.op;
            r_blk <= KB'(i_req.block);
            r_din <= i_req.dirty_in;
        end
        if (i_cmd.match) begin
            r_hit    <= m_hit & has_blk;
            r_hslot  <= m_slot;
            r_hdirty <= r_dirty[m_slot];
        end
        if (emit) begin
            r_kind  <= n_kind;
            r_rblk  <= n_rblk;
            r_found <= n_found;
            r_dout  <= n_dout;
            r_slot  <= n_slot;
            r_last  <= i_cmd.finish;
        end
    end

    assign i_req.ready       = i_cmd.in_ready;
    assign o_rsp.valid       = r_ov;
    assign o_rsp.kind        = r_kind;
    assign o_rsp.report_block = r_rblk;
    assign o_rsp.found       = r_found;
    assign o_rsp.dirty_out   = r_dout;
    assign o_rsp.slot        = r_slot;
    assign o_rsp.last        = r_last;
    assign o_rsp.occupancy   = 5'(r_vc);
    assign o_rsp.hit_total   = r_hits;
    assign o_rsp.miss_total  = r_miss;
    assign o_rsp.evict_total = r_evs;

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == 32'(r_vc))
        else $error("valid bits disagree with occupancy");
    a_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_vc) <= 32'(ENTRIES))
        else $error("occupancy above entry count");
    a_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> out_free)
        else $error("result written over a pending one");
    a_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.evict |=> (r_ov && r_kind == lbcd_pkg::KIND_EVICT))
        else $error("eviction without report");

endmodule

// File: rtl/lru_block_cache_directory_core.sv
`timescale 1ns / 1ps

// Fully associative block cache directory with least-recently-used replacement and dirty
// marks; each request is one command and produces zero or more eviction or flush reports
// followed by one status result marked last. A request passes through capture, parallel
// tag compare, then update and status. A fill adds an eviction step that emits one report
// per eviction, and a flush scan walks each valid entry in rank order before its status.
// The controller accepts the next request only after the status result has been loaded
// into the output register, and a stalled output holds the walk at the next report.

module lru_block_cache_directory_core #(
    parameter int ENTRIES        = 16,
    parameter int BLOCK_NUM_BITS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_index,
    input  logic [4:0] i_cfg_data,
    lbcd_req_if.sink   i_req,
    lbcd_rsp_if.source o_rsp
);

    lbcd_pkg::t_cmd    cmd;
    lbcd_pkg::t_status status;
    logic              load;

    lbcd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_cmd    (cmd)
    );

    lbcd_datapath #(
        .ENTRIES        (ENTRIES),
        .BLOCK_NUM_BITS (BLOCK_NUM_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_load      (load),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_req       (i_req),
        .o_rsp       (o_rsp)
    );

    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> !i_req.ready)
        else $error("request taken while busy");

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int NSLOT = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [3:0] OP_UNKNOWN_LO = 4'd10;
    localparam logic [3:0] OP_UNKNOWN_HI = 4'd15;

    typedef struct {
        logic [1:0]  kind;
        logic [31:0] blk;
        logic        found;
        logic        dirty;
        logic [3:0]  slot;
        logic        last;
        logic [4:0]  occ;
        logic [31:0] hits;
        logic [31:0] misses;
        logic [31:0] evicts;
    } t_report;

    typedef struct {
        logic [3:0]  op;
        logic [31:0] blk;
        logic        din;
        logic        has_status;
        t_report     status;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_wr_en = 1'b0;
    logic i_cfg_index = 1'b0;
    logic [4:0] i_cfg_data = '0;

    lbcd_req_if req_ch ();
    lbcd_rsp_if rsp_ch ();

    lru_block_cache_directory_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_req(req_ch.sink), .o_rsp(rsp_ch.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [31:0] dir_block [NSLOT];
    logic        dir_valid [NSLOT];
    logic        dir_dirty [NSLOT];
    int          dir_rank [NSLOT];
    int          dir_count;
    logic [31:0] hit_cnt, miss_cnt, evict_cnt;
    logic [4:0]  cap_reg;
    logic        wt_reg;

    t_report pending_reports[$];
    t_report typed_status[$];
    int errors = 0;
    int req_count = 0;
    int rsp_count = 0;
    int evict_seen = 0;
    int flush_seen = 0;
    longint cycles = 0;
    bit sink_idle_on = 1'b1;
    bit hold_off = 1'b0;

    function automatic logic [31:0] bump(logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    function automatic void push_report(logic [1:0] k, logic [31:0] b, logic f,
                                        logic d, int s, logic l);
        t_report r;
        r.kind = k; r.blk = b; r.found = f; r.dirty = d; r.slot = s[3:0]; r.last = l;
        r.occ = dir_count[4:0]; r.hits = hit_cnt; r.misses = miss_cnt;
        r.evicts = evict_cnt;
        pending_reports.insert(pending_reports.size(), r);
    endfunction

    function automatic int slot_of_rank(int r);
        for (int i = 0; i < NSLOT; i++)
            if (dir_valid[i] && dir_rank[i] == r) return i;
        return -1;
    endfunction

    function automatic void promote(int s);
        int r;
        r = dir_rank[s];
        for (int j = 0; j < NSLOT; j++)
            if (dir_valid[j] && dir_rank[j] < r) dir_rank[j]++;
        dir_rank[s] = 0;
    endfunction

    function automatic void drop_slot(int s);
        int r;
        r = dir_rank[s];
        dir_valid[s] = 1'b0;
        dir_dirty[s] = 1'b0;
        for (int j = 0; j < NSLOT; j++)
            if (dir_valid[j] && dir_rank[j] > r) dir_rank[j]--;
        if (dir_count > 0) dir_count--;
    endfunction

    function automatic void directory_clear();
        for (int i = 0; i < NSLOT; i++) begin
            dir_valid[i] = 1'b0; dir_dirty[i] = 1'b0; dir_rank[i] = 0; dir_block[i] = '0;
        end
        dir_count = 0; hit_cnt = '0; miss_cnt = '0; evict_cnt = '0;
        cap_reg = lbcd_pkg::CAPACITY_RESET; wt_reg = 1'b0;
    endfunction

    function automatic void predict_directory(logic [3:0] op, logic [31:0] blk, logic din);
        int s, v, i, cap;
        logic found, dout, has_blk;
        int slot;
        found = 1'b0; dout = 1'b0; slot = 0; s = -1;
        has_blk = (op <= lbcd_pkg::OP_INVALIDATE);
        if (has_blk)
            for (int j = 0; j < NSLOT; j++)
                if (s < 0 && dir_valid[j] && dir_block[j] == blk) s = j;
        if (s >= 0) begin
            found = 1'b1; slot = s; dout = dir_dirty[s];
        end
        case (op)
            lbcd_pkg::OP_LOOKUP: begin
                if (s >= 0) begin
                    promote(s); hit_cnt = bump(hit_cnt);
                end else begin
                    miss_cnt = bump(miss_cnt);
                end
            end
            lbcd_pkg::OP_FILL: begin
                if (s >= 0) begin
                    dir_dirty[s] = wt_reg ? 1'b0 : (dir_dirty[s] | din);
                    promote(s);
                end else begin
                    cap = (cap_reg == 0) ? 1 : int'(cap_reg);
                    if (cap > NSLOT) cap = NSLOT;
                    while (dir_count >= cap && dir_count > 0) begin
                        logic d;
                        logic [31:0] b;
                        v = slot_of_rank(dir_count - 1);
                        if (v < 0) break;
                        d = dir_dirty[v]; b = dir_block[v];
                        drop_slot(v);
                        evict_cnt = bump(evict_cnt);
                        push_report(lbcd_pkg::KIND_EVICT, b, 1'b0, d, v, 1'b0);
                    end
                    for (i = 0; i < NSLOT; i++)
                        if (!dir_valid[i]) break;
                    if (i < NSLOT) begin
                        for (int j = 0; j < NSLOT; j++)
                            if (dir_valid[j]) dir_rank[j]++;
                        dir_valid[i] = 1'b1; dir_block[i] = blk;
                        dir_dirty[i] = wt_reg ? 1'b0 : din;
                        dir_rank[i] = 0; dir_count++;
                        s = i;
                    end
                end
                if (s >= 0) begin
                    slot = s; dout = dir_dirty[s];
                end
            end
            lbcd_pkg::OP_MARK_DIRTY: if (s >= 0) begin
                dir_dirty[s] = 1'b1; dout = 1'b1;
            end
            lbcd_pkg::OP_CLEAR_DIRTY: if (s >= 0) begin
                dir_dirty[s] = 1'b0; dout = 1'b0;
            end
            lbcd_pkg::OP_INVALIDATE: if (s >= 0) drop_slot(s);
            lbcd_pkg::OP_FLUSH: begin
                for (int r = 0; r < dir_count; r++) begin
                    int e;
                    e = slot_of_rank(r);
                    if (e >= 0 && dir_dirty[e]) begin
                        dir_dirty[e] = 1'b0;
                        push_report(lbcd_pkg::KIND_FLUSH, dir_block[e], 1'b0, 1'b1, e, 1'b0);
                    end
                end
            end
            lbcd_pkg::OP_CLEAR_ALL: begin
                for (int j = 0; j < NSLOT; j++) begin
                    dir_valid[j] = 1'b0; dir_dirty[j] = 1'b0;
                end
                dir_count = 0;
            end
            lbcd_pkg::OP_CLEAN_ALL: for (int j = 0; j < NSLOT; j++) dir_dirty[j] = 1'b0;
            lbcd_pkg::OP_RESET_STATS: begin
                hit_cnt = '0; miss_cnt = '0; evict_cnt = '0;
            end
            default: ;
        endcase
        push_report(lbcd_pkg::KIND_STATUS, has_blk ? blk : 32'd0, found, dout, slot, 1'b1);
    endfunction

    function automatic t_report make_status(logic [31:0] b, int f, int d, int s,
                                            int occ, int h, int m, int e);
        t_report r;
        r.kind = lbcd_pkg::KIND_STATUS; r.blk = b; r.found = f[0]; r.dirty = d[0];
        r.slot = s[3:0]; r.last = 1'b1; r.occ = occ[4:0]; r.hits = h; r.misses = m;
        r.evicts = e;
        return r;
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else if (hold_off) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= sink_idle_on ? ($urandom_range(99) >= 26) : 1'b1;
        end
    end

    function automatic void compare_field(string name, logic [31:0] exp_v, logic [31:0] act);
        if (exp_v !== act) begin
            $error("%s mismatch: expected %0h, got %0h", name, exp_v, act);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_report e;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            rsp_count++;
            if (pending_reports.size() == 0) begin
                $error("response with no request outstanding: kind %0d", rsp_ch.kind);
                errors++;
            end else begin
                e = pending_reports.pop_front();
                if (rsp_ch.kind == lbcd_pkg::KIND_EVICT) evict_seen++;
                if (rsp_ch.kind == lbcd_pkg::KIND_FLUSH) flush_seen++;
                compare_field("kind", e.kind, rsp_ch.kind);
                compare_field("report_block", e.blk, rsp_ch.report_block);
                compare_field("found", e.found, rsp_ch.found);
                compare_field("dirty_out", e.dirty, rsp_ch.dirty_out);
                compare_field("slot", e.slot, rsp_ch.slot);
                compare_field("last", e.last, rsp_ch.last);
                compare_field("occupancy", e.occ, rsp_ch.occupancy);
                compare_field("hit_total", e.hits, rsp_ch.hit_total);
                compare_field("miss_total", e.misses, rsp_ch.miss_total);
                compare_field("evict_total", e.evicts, rsp_ch.evict_total);
                if (e.last && typed_status.size() > 0) begin
                    e = typed_status.pop_front();
                    compare_field("report_block", e.blk, rsp_ch.report_block);
                    compare_field("found", e.found, rsp_ch.found);
                    compare_field("dirty_out", e.dirty, rsp_ch.dirty_out);
                    compare_field("slot", e.slot, rsp_ch.slot);
                    compare_field("occupancy", e.occ, rsp_ch.occupancy);
                    compare_field("hit_total", e.hits, rsp_ch.hit_total);
                    compare_field("miss_total", e.misses, rsp_ch.miss_total);
                    compare_field("evict_total", e.evicts, rsp_ch.evict_total);
                end
            end
        end
    end

    bit src_idle_on = 1'b1;

    task automatic send_request(logic [3:0] op, logic [31:0] blk, logic din);
        if (src_idle_on)
            while ($urandom_range(99) < 26) begin
                req_ch.valid <= 1'b0;
                @(posedge i_clk);
            end
        req_ch.valid <= 1'b1;
        req_ch.op <= op;
        req_ch.block <= blk;
        req_ch.dirty_in <= din;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        predict_directory(op, blk, din);
        req_count++;
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [4:0] val);
        drain();
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (idx == lbcd_pkg::CFG_CAPACITY) cap_reg = val;
        else wt_reg = val[0];
    endtask

    function automatic logic [31:0] pick_block(logic [31:0] base);
        case ($urandom_range(9))
            0: return $urandom();
            1: return 32'hFFFF_FFFF - $urandom_range(3);
            default: return base + $urandom_range(23);
        endcase
    endfunction

    task automatic random_phase(int n, logic [31:0] base);
        logic [3:0] op;
        int w;
        for (int k = 0; k < n; k++) begin
            w = $urandom_range(99);
            if (w < 35) op = lbcd_pkg::OP_FILL;
            else if (w < 60) op = lbcd_pkg::OP_LOOKUP;
            else if (w < 67) op = lbcd_pkg::OP_PROBE;
            else if (w < 74) op = lbcd_pkg::OP_MARK_DIRTY;
            else if (w < 79) op = lbcd_pkg::OP_CLEAR_DIRTY;
            else if (w < 86) op = lbcd_pkg::OP_INVALIDATE;
            else if (w < 92) op = lbcd_pkg::OP_FLUSH;
            else if (w < 94) op = lbcd_pkg::OP_CLEAR_ALL;
            else if (w < 96) op = lbcd_pkg::OP_CLEAN_ALL;
            else if (w < 97) op = lbcd_pkg::OP_RESET_STATS;
            else op = 4'($urandom_range(int'(OP_UNKNOWN_HI), int'(OP_UNKNOWN_LO)));
            send_request(op, pick_block(base), 1'($urandom_range(1)));
        end
    endtask

    t_row rows[$];

    task automatic add_row(logic [3:0] op, logic [31:0] blk, logic din, bit typed,
                           t_report st);
        t_row r;
        r.op = op; r.blk = blk; r.din = din; r.has_status = typed; r.status = st;
        rows.insert(rows.size(), r);
    endtask

    initial begin
        t_report none;
        none = make_status(32'h0, 0, 0, 0, 0, 0, 0, 0);
        req_ch.valid = 1'b0;
        req_ch.op = lbcd_pkg::OP_LOOKUP;
        req_ch.block = '0;
        req_ch.dirty_in = 1'b0;
        directory_clear();

        add_row(lbcd_pkg::OP_LOOKUP, 32'h0, 1'b0, 1'b1,
                make_status(32'h0, 0, 0, 0, 0, 0, 1, 0));
        add_row(lbcd_pkg::OP_FILL, 32'hFFFF_FFFF, 1'b1, 1'b1,
                make_status(32'hFFFF_FFFF, 0, 1, 0, 1, 0, 1, 0));
        add_row(lbcd_pkg::OP_FILL, 32'h0, 1'b0, 1'b1,
                make_status(32'h0, 0, 0, 1, 2, 0, 1, 0));
        add_row(lbcd_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 1'b0, 1'b1,
                make_status(32'hFFFF_FFFF, 1, 1, 0, 2, 1, 1, 0));
        add_row(lbcd_pkg::OP_PROBE, 32'h0, 1'b0, 1'b1,
                make_status(32'h0, 1, 0, 1, 2, 1, 1, 0));
        add_row(lbcd_pkg::OP_MARK_DIRTY, 32'h0, 1'b0, 1'b1,
                make_status(32'h0, 1, 1, 1, 2, 1, 1, 0));
        add_row(lbcd_pkg::OP_FLUSH, 32'h0, 1'b0, 1'b0, none);
        add_row(lbcd_pkg::OP_MARK_DIRTY, 32'h5555_AAAA, 1'b0, 1'b1,
                make_status(32'h5555_AAAA, 0, 0, 0, 2, 1, 1, 0));
        add_row(lbcd_pkg::OP_FILL, 32'hAAAA_5555, 1'b1, 1'b0, none);
        add_row(lbcd_pkg::OP_FILL, 32'h0, 1'b1, 1'b0, none);
        add_row(lbcd_pkg::OP_CLEAR_DIRTY, 32'h0, 1'b0, 1'b0, none);
        add_row(lbcd_pkg::OP_INVALIDATE, 32'hFFFF_FFFF, 1'b0, 1'b0, none);
        add_row(lbcd_pkg::OP_INVALIDATE, 32'h1234_5678, 1'b0, 1'b0, none);
        add_row(lbcd_pkg::OP_FILL, 32'h1234_5678, 1'b1, 1'b0, none);
        add_row(lbcd_pkg::OP_CLEAN_ALL, 32'h0, 1'b0, 1'b0, none);
        add_row(lbcd_pkg::OP_FLUSH, 32'h0, 1'b0, 1'b0, none);
        add_row(OP_UNKNOWN_HI, 32'hFFFF_FFFF, 1'b1, 1'b0, none);
        add_row(OP_UNKNOWN_LO, 32'h0, 1'b0, 1'b0, none);
        add_row(lbcd_pkg::OP_RESET_STATS, 32'h0, 1'b0, 1'b0, none);
        add_row(lbcd_pkg::OP_CLEAR_ALL, 32'h0, 1'b0, 1'b1,
                make_status(32'h0, 0, 0, 0, 0, 0, 0, 0));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[n]) begin
            if (rows[n].has_status) begin
                drain();
                typed_status.insert(typed_status.size(), rows[n].status);
            end
            send_request(rows[n].op, rows[n].blk, rows[n].din);
            if (rows[n].has_status) drain();
        end

        write_reg(lbcd_pkg::CFG_CAPACITY, 5'd1);
        for (int k = 0; k < 4; k++)
            send_request(lbcd_pkg::OP_FILL, 32'h100 + 32'(k), k[0]);
        write_reg(lbcd_pkg::CFG_WRITE_THROUGH, 5'd1);
        write_reg(lbcd_pkg::CFG_CAPACITY, 5'd0);
        random_phase(25, 32'h200);
        write_reg(lbcd_pkg::CFG_WRITE_THROUGH, 5'd0);
        write_reg(lbcd_pkg::CFG_CAPACITY, 5'd31);
        for (int k = 0; k < 17; k++)
            send_request(lbcd_pkg::OP_FILL, 32'h300 + 32'(k), 1'b1);
        send_request(lbcd_pkg::OP_FLUSH, 32'h0, 1'b0);

        fork
            begin
                hold_off = 1'b1;
                repeat (200) @(posedge i_clk);
                hold_off = 1'b0;
            end
            random_phase(20, 32'h300);
        join
        drain();

        write_reg(lbcd_pkg::CFG_CAPACITY, 5'd4);
        random_phase(40, 32'h400);
        write_reg(lbcd_pkg::CFG_CAPACITY, 5'd16);
        src_idle_on = 1'b0;
        sink_idle_on = 1'b0;
        random_phase(30, 32'h500);
        src_idle_on = 1'b1;
        sink_idle_on = 1'b1;
        write_reg(lbcd_pkg::CFG_CAPACITY, 5'd9);
        random_phase(40, 32'h600);
        write_reg(lbcd_pkg::CFG_WRITE_THROUGH, 5'd1);
        random_phase(20, 32'h600);
        drain();

        $display("Sent %0d requests, checked %0d responses (%0d evictions, %0d flushes).",
                 req_count, rsp_count, evict_seen, flush_seen);
        if (errors == 0 && pending_reports.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end
endmodule
